// ----- sv/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

	// request codes carried in the input item's tuser
	localparam logic [2:0] REQ_PUSH_REAR  = 3'd0;
	localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
	localparam logic [2:0] REQ_POP_REAR   = 3'd2;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd3;
	localparam logic [2:0] REQ_CLEAR      = 3'd4;

	// status codes reported with each result
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_POP_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_PUSH_FULL  = 2'd2;

	// value reported for front and rear of an empty queue
	localparam logic signed [31:0] INT_MIN = {1'b1, 31'b0};

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic push_rear;
		logic push_front;
		logic pop_rear;
		logic pop_front;
		logic clear;
	} deq_ctl_t;

endpackage

`default_nettype wire

// ----- sv/deq_cell.sv -----
// ----------------------------------------------------------------------------
// deq_cell
// One entry of the queue chain: a data word and an occupancy bit, shifted
// toward either neighbor or loaded in place as the command requires.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_cell
	import deq_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire deq_ctl_t           ctl,
	input  wire logic signed [31:0] push_value,
	input  wire logic signed [31:0] left_data,
	input  wire                     left_valid,
	input  wire logic signed [31:0] right_data,
	input  wire                     right_valid,
	output logic signed [31:0]      data_q,
	output logic                    valid_q,
	output logic signed [31:0]      nxt_data,
	output logic                    nxt_valid
);

	// next contents of this entry
	always_comb begin
		nxt_data  = data_q;
		nxt_valid = valid_q;
		if (ctl.clear) begin
			nxt_valid = 1'b0;
		end else if (ctl.push_front) begin
			nxt_data  = left_data;
			nxt_valid = valid_q | left_valid;
		end else if (ctl.push_rear) begin
			// the first free entry takes the new value
			if (!valid_q && left_valid) begin
				nxt_data = push_value;
			end
			nxt_valid = valid_q | left_valid;
		end else if (ctl.pop_front) begin
			nxt_data  = right_data;
			nxt_valid = valid_q & right_valid;
		end else if (ctl.pop_rear) begin
			nxt_valid = valid_q & right_valid;
		end
	end

	// occupancy bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt_valid;
		end
	end

	// data word
	always_ff @(posedge clk) begin
		data_q <= nxt_data;
	end

endmodule

`default_nettype wire

// ----- sv/double_ended_queue_top.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit values in a chain of DEPTH cells.
// ----------------------------------------------------------------------------
// Each request item (push rear, push front, pop rear, pop front, clear) gives
// one result item holding front, rear, entry count, empty flag and status.
// One item is accepted per cycle and its result appears in the output
// register on the next cycle; a new item is taken while that result waits as
// long as the result is being taken in the same cycle. The front entry always
// sits in cell 0 and the chain shifts one cell per push front or pop front;
// the cycle time is set by the chain update feeding the rear select, which
// spans all DEPTH cells. No clearing pass is needed after reset.
`default_nettype none

module double_ended_queue_top
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,  // push_value[31:0]
	input  wire  [2:0]  s_tuser,  // req_type[2:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [71:0] m_tdata   // front_value[31:0], rear_value[63:32],
	                              // entry_count[68:64], is_empty[69], status[71:70]
);

	localparam int unsigned CW   = $clog2(DEPTH + 1);
	localparam int unsigned EXTW = CW + 5;

	logic                     accept;
	logic [2:0]               req_type;
	logic signed [31:0]       push_value;
	logic                     full;
	logic                     empty;
	deq_ctl_t                 ctl;
	logic [1:0]               status;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_nxt;
	logic [EXTW-1:0]          count_ext;

	logic signed [31:0]       cell_data     [DEPTH];
	logic signed [31:0]       cell_nxt_data [DEPTH];
	logic [DEPTH-1:0]         cell_valid;
	logic [DEPTH-1:0]         cell_nxt_valid;
	logic [DEPTH-1:0]         rear_sel;

	logic signed [31:0]       front_nxt;
	logic signed [31:0]       rear_nxt;
	logic                     empty_nxt;

	assign accept     = s_tvalid & s_tready;
	assign s_tready   = ~m_tvalid | m_tready;
	assign req_type   = s_tuser;
	assign push_value = s_tdata;
	assign full       = cell_valid[DEPTH-1];
	assign empty      = ~cell_valid[0];

	// request decode and status
	always_comb begin
		ctl    = '0;
		status = STAT_OK;
		if (accept) begin
			unique case (req_type)
				REQ_PUSH_REAR: begin
					if (full) status = STAT_PUSH_FULL;
					else      ctl.push_rear = 1'b1;
				end
				REQ_PUSH_FRONT: begin
					if (full) status = STAT_PUSH_FULL;
					else      ctl.push_front = 1'b1;
				end
				REQ_POP_REAR: begin
					if (empty) status = STAT_POP_EMPTY;
					else       ctl.pop_rear = 1'b1;
				end
				REQ_POP_FRONT: begin
					if (empty) status = STAT_POP_EMPTY;
					else       ctl.pop_front = 1'b1;
				end
				REQ_CLEAR: begin
					ctl.clear = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// entry count
	always_comb begin
		count_nxt = count_q;
		if (ctl.clear) begin
			count_nxt = '0;
		end else if (ctl.push_rear || ctl.push_front) begin
			count_nxt = count_q + CW'(1);
		end else if (ctl.pop_rear || ctl.pop_front) begin
			count_nxt = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// chain of cells, front at cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] left_data;
		logic               left_valid;
		logic signed [31:0] right_data;
		logic               right_valid;

		if (i == 0) begin : g_first
			assign left_data  = push_value;
			assign left_valid = 1'b1;
		end else begin : g_inner_l
			assign left_data  = cell_data[i-1];
			assign left_valid = cell_valid[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data  = cell_data[i];
			assign right_valid = 1'b0;
			assign rear_sel[i] = cell_nxt_valid[i];
		end else begin : g_inner_r
			assign right_data  = cell_data[i+1];
			assign right_valid = cell_valid[i+1];
			assign rear_sel[i] = cell_nxt_valid[i] & ~cell_nxt_valid[i+1];
		end

		deq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.push_value  (push_value),
			.left_data   (left_data),
			.left_valid  (left_valid),
			.right_data  (right_data),
			.right_valid (right_valid),
			.data_q      (cell_data[i]),
			.valid_q     (cell_valid[i]),
			.nxt_data    (cell_nxt_data[i]),
			.nxt_valid   (cell_nxt_valid[i])
		);
	end

	// front and rear after the request
	always_comb begin
		empty_nxt = ~cell_nxt_valid[0];
		rear_nxt  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_nxt = rear_nxt | (cell_nxt_data[i] & {32{rear_sel[i]}});
		end
		front_nxt = cell_nxt_data[0];
		if (empty_nxt) begin
			front_nxt = INT_MIN;
			rear_nxt  = INT_MIN;
		end
	end

	assign count_ext = EXTW'(count_nxt);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_tready) begin
			m_tvalid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata <= {status, empty_nxt, count_ext[4:0], rear_nxt, front_nxt};
		end
	end

endmodule

`default_nettype wire

// ----- verif/double_ended_queue_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// Self-checking bench for the double-ended queue.
// ----------------------------------------------------------------------------
// Requests are driven on the slave stream with random gaps. A shadow deque
// inside the scoreboard computes the front, rear, count, empty flag and status
// that each accepted request should give. Every result taken from the master
// stream is checked field by field against the oldest pending snapshot. The
// run starts with directed corner cases: pops on empty, extreme values, unused
// codes, a full queue and clear. It then runs random fill, drain and mixed
// bursts, with one long output hold-off and one full drain pause.

module double_ended_queue_top_tb;
	import deq_pkg::*;

	localparam int unsigned QDEPTH        = 16;
	localparam int unsigned ITEM_TARGET   = 1750;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned STALL_LIMIT   = 3000;
	localparam int unsigned MAX_ERR_LINES = 30;

	// request codes the block ignores
	localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

	typedef enum int unsigned {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX
	} burst_mode_t;

	// one expected result item
	typedef struct {
		logic [31:0] front;
		logic [31:0] rear;
		logic [4:0]  count;
		logic        empty;
		logic [1:0]  status;
	} deq_view_t;

	class deque_scoreboard #(int unsigned DEPTH = 16);
		logic [31:0] slot_mem [DEPTH];
		int unsigned head_ptr;
		int unsigned tail_ptr;
		int unsigned fill;
		deq_view_t   snapshot_q [$];
		int unsigned error_count;

		function new();
			head_ptr    = 0;
			tail_ptr    = 0;
			fill        = 0;
			error_count = 0;
		endfunction

		// apply one accepted request to the shadow deque and queue its view
		function void note_request(logic [2:0] req, logic [31:0] value);
			deq_view_t  view;
			logic [1:0] stat;
			stat = STAT_OK;
			case (req)
				REQ_PUSH_REAR: begin
					if (fill >= DEPTH) begin
						stat = STAT_PUSH_FULL;
					end else begin
						slot_mem[tail_ptr] = value;
						tail_ptr = (tail_ptr + 1) % DEPTH;
						fill++;
					end
				end
				REQ_PUSH_FRONT: begin
					if (fill >= DEPTH) begin
						stat = STAT_PUSH_FULL;
					end else begin
						head_ptr = (head_ptr + DEPTH - 1) % DEPTH;
						slot_mem[head_ptr] = value;
						fill++;
					end
				end
				REQ_POP_REAR: begin
					if (fill == 0) begin
						stat = STAT_POP_EMPTY;
					end else begin
						tail_ptr = (tail_ptr + DEPTH - 1) % DEPTH;
						fill--;
					end
				end
				REQ_POP_FRONT: begin
					if (fill == 0) begin
						stat = STAT_POP_EMPTY;
					end else begin
						head_ptr = (head_ptr + 1) % DEPTH;
						fill--;
					end
				end
				REQ_CLEAR: begin
					head_ptr = 0;
					tail_ptr = 0;
					fill     = 0;
				end
				default: ;
			endcase
			if (fill == 0) begin
				view.front = INT_MIN;
				view.rear  = INT_MIN;
			end else begin
				view.front = slot_mem[head_ptr];
				view.rear  = slot_mem[(tail_ptr + DEPTH - 1) % DEPTH];
			end
			view.count  = 5'(fill);
			view.empty  = (fill == 0);
			view.status = stat;
			snapshot_q.push_back(view);
		endfunction

		task report(string msg);
			error_count++;
			if (error_count <= MAX_ERR_LINES)
				$display("ERROR @%0t: %0s", $realtime, msg);
		endtask

		// compare one result item against the oldest pending view
		task check_result(logic [71:0] data);
			deq_view_t want;
			deq_view_t got;
			got.front  = data[31:0];
			got.rear   = data[63:32];
			got.count  = data[68:64];
			got.empty  = data[69];
			got.status = data[71:70];
			if (snapshot_q.size() == 0) begin
				report($sformatf("result with nothing pending: %h", data));
			end else begin
				want = snapshot_q.pop_front();
				if (got.front !== want.front)
					report($sformatf("front got %h exp %h", got.front, want.front));
				if (got.rear !== want.rear)
					report($sformatf("rear got %h exp %h", got.rear, want.rear));
				if (got.count !== want.count)
					report($sformatf("count got %0d exp %0d", got.count, want.count));
				if (got.empty !== want.empty)
					report($sformatf("empty got %b exp %b", got.empty, want.empty));
				if (got.status !== want.status)
					report($sformatf("status got %0d exp %0d", got.status, want.status));
			end
		endtask

		function int unsigned pending();
			return snapshot_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;

	deque_scoreboard #(QDEPTH) sb;
	int unsigned sent_count;
	bit          steady;
	bit          hold_off_req;

	double_ended_queue_top #(
		.DEPTH(QDEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one request item and wait until it is taken
	task automatic send_req(input logic [2:0] req, input logic [31:0] value);
		if (!steady) begin
			while ($urandom_range(99) < 28) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		sb.note_request(req, value);
		sent_count++;
	endtask

	// stop offering until every pending result has come back
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(15))
			0:       return INT_MIN;
			1:       return 32'h7fff_ffff;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// result side: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= steady || ($urandom_range(99) >= 28);
		end
	end

	// check every result item taken
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// watchdog on cycles with no item moving on either side
	initial begin : watchdog
		int unsigned stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("ERROR: no progress for %0d cycles", STALL_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		burst_mode_t mode;
		int unsigned burst_len;
		int unsigned push_pct;
		logic [2:0]  req;
		bit          hold_done;
		bit          pause_done;
		sb           = new();
		sent_count   = 0;
		steady       = 1'b0;
		hold_off_req = 1'b0;
		hold_done    = 1'b0;
		pause_done   = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pops on an empty queue
		send_req(REQ_POP_REAR, 32'h1234_5678);
		send_req(REQ_POP_FRONT, 32'hffff_ffff);
		// extreme values at both ends
		send_req(REQ_PUSH_REAR, INT_MIN);
		send_req(REQ_PUSH_FRONT, 32'h7fff_ffff);
		send_req(REQ_PUSH_REAR, 32'h0000_0000);
		send_req(REQ_PUSH_FRONT, 32'hffff_ffff);
		// unused codes leave the queue alone
		send_req(REQ_UNUSED_LO, 32'hdead_beef);
		send_req(REQ_UNUSED_LO + 3'd1, 32'h5555_5555);
		send_req(REQ_UNUSED_HI, 32'haaaa_aaaa);
		send_req(REQ_POP_FRONT, 32'h0);
		send_req(REQ_POP_REAR, 32'h0);
		// fill up, then push on full at both ends
		for (int i = 0; i < QDEPTH - 2; i++)
			send_req(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_REAR, pick_value());
		send_req(REQ_PUSH_REAR, 32'h0bad_0bad);
		send_req(REQ_PUSH_FRONT, 32'h0bad_0bad);
		send_req(REQ_CLEAR, 32'h0);
		wait_for_drain();

		// random bursts
		while (sent_count < ITEM_TARGET) begin
			steady = (sent_count >= 700 && sent_count < 1000);
			if (!hold_done && sent_count >= 400) begin
				hold_off_req = 1'b1;
				hold_done    = 1'b1;
			end
			if (!pause_done && sent_count >= 1200) begin
				wait_for_drain();
				pause_done = 1'b1;
			end
			mode      = burst_mode_t'($urandom_range(2));
			burst_len = $urandom_range(40, 8);
			case (mode)
				MODE_FILL:  push_pct = 85;
				MODE_DRAIN: push_pct = 15;
				default:    push_pct = 50;
			endcase
			repeat (burst_len) begin
				if (mode == MODE_MIX && $urandom_range(99) < 6)
					req = REQ_CLEAR;
				else if ($urandom_range(99) < 2)
					req = 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
				else if ($urandom_range(99) < push_pct)
					req = $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR;
				else
					req = $urandom_range(1) ? REQ_POP_FRONT : REQ_POP_REAR;
				send_req(req, pick_value());
			end
		end

		// let the last results drain out
		steady = 1'b0;
		wait_for_drain();
		repeat (8) @(posedge clk);
		if (sb.error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
